// ----- hdl/assert_macros.svh -----
// assertion macros shared by the touch gesture decoder rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- hdl/ttgd_pkg.sv -----
// shared types and constants for the touch tap gesture decoder
// no dependencies
package ttgd_pkg;

  localparam int SAMPLE_WIDTH_DEFAULT = 16;
  localparam int TIME_WIDTH_DEFAULT   = 32;

  localparam int SAMPLE_PORT_WIDTH = 16;
  localparam int TIME_PORT_WIDTH   = 32;
  localparam int THRESHOLD_WIDTH   = 16;
  localparam int READS_WIDTH       = 3;
  localparam int MS_WIDTH          = 16;
  localparam int CFG_DATA_WIDTH    = 16;
  localparam int CFG_INDEX_WIDTH   = 2;

  // register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOUCH_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE_READS  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS_MS   = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TAP_WINDOW_MS   = 2'd3;

  // register reset values
  localparam logic [THRESHOLD_WIDTH-1:0] THRESHOLD_RESET  = 16'd40;
  localparam logic [READS_WIDTH-1:0]     READS_RESET      = 3'd3;
  localparam logic [MS_WIDTH-1:0]        LONG_PRESS_RESET = 16'd600;
  localparam logic [MS_WIDTH-1:0]        DOUBLE_TAP_RESET = 16'd280;

  // pulse sequencer phases
  localparam logic [1:0] PHASE_IDLE    = 2'd0;
  localparam logic [1:0] PHASE_RELEASE = 2'd1;
  localparam logic [1:0] PHASE_PRESS   = 2'd2;
  localparam logic [1:0] PHASE_UNUSED  = 2'd3;

  typedef struct packed {
    logic [THRESHOLD_WIDTH-1:0] touch_threshold;
    logic [READS_WIDTH-1:0]     debounce_reads;
    logic [MS_WIDTH-1:0]        long_press_ms;
    logic [MS_WIDTH-1:0]        tap_window_ms;
  } cfg_t;

  typedef struct packed {
    logic                       a_pressed;
    logic                       a_was_pressed;
    logic                       a_was_released;
    logic [TIME_PORT_WIDTH-1:0] a_press_time;
    logic                       b_pressed;
    logic                       b_was_pressed;
    logic                       b_was_released;
    logic [TIME_PORT_WIDTH-1:0] b_press_time;
  } result_t;

endpackage

// ----- hdl/touch_tap_gesture_decoder.sv -----
// top level of the touch tap gesture decoder: config registers, input and result stages
// depends on ttgd_pkg, ttgd_debounce, ttgd_gesture and assert_macros.svh
`include "assert_macros.svh"

// Turns a capacitive touch pad into two virtual buttons. Each input transaction is
// one poll (sample plus millisecond timestamp); each produces exactly one result
// transaction with the level, press edge, release edge and press timestamp of
// buttons A and B. A press held for long_press_ms holds A down until release; two
// taps within the tap window pulse B for one poll; a lone tap pulses A once the
// window lapses. The block takes one poll every clock cycle while the result
// channel is not stalled. A poll waits in the input register until the result
// register is free or being drained, and its result is then written to the
// result register; the gesture state is read and rewritten for every poll.
// The result register and the input register decouple the two sides, so one
// more poll is still taken while a finished result waits. Configuration writes
// (cfg_write, cfg_index, cfg_data) take effect at once and belong to idle
// periods only; config registers, valid flags and gesture state reset on rst.
module touch_tap_gesture_decoder #(
  parameter int SAMPLE_WIDTH = ttgd_pkg::SAMPLE_WIDTH_DEFAULT,
  parameter int TIME_WIDTH   = ttgd_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write port
  input  logic                                  cfg_write,
  input  logic [ttgd_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [ttgd_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
  // poll input channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ttgd_pkg::SAMPLE_PORT_WIDTH-1:0] touch_sample,
  input  logic [ttgd_pkg::TIME_PORT_WIDTH-1:0]   now_ms,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  a_pressed,
  output logic                                  a_was_pressed,
  output logic                                  a_was_released,
  output logic [ttgd_pkg::TIME_PORT_WIDTH-1:0]   a_press_time,
  output logic                                  b_pressed,
  output logic                                  b_was_pressed,
  output logic                                  b_was_released,
  output logic [ttgd_pkg::TIME_PORT_WIDTH-1:0]   b_press_time
);

  ttgd_pkg::cfg_t    cfg;
  ttgd_pkg::result_t res;
  ttgd_pkg::result_t result;

  // input register
  logic                    stage_valid;
  logic [SAMPLE_WIDTH-1:0] stage_sample;
  logic [TIME_WIDTH-1:0]   stage_now;

  logic advance;
  logic down;

  // the staged poll moves on when the result register is free or being drained
  assign advance  = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || advance;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.touch_threshold <= ttgd_pkg::THRESHOLD_RESET;
      cfg.debounce_reads  <= ttgd_pkg::READS_RESET;
      cfg.long_press_ms   <= ttgd_pkg::LONG_PRESS_RESET;
      cfg.tap_window_ms   <= ttgd_pkg::DOUBLE_TAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        ttgd_pkg::REG_TOUCH_THRESHOLD: begin
          cfg.touch_threshold <= ttgd_pkg::THRESHOLD_WIDTH'(cfg_data);
        end
        ttgd_pkg::REG_DEBOUNCE_READS: begin
          cfg.debounce_reads <= cfg_data[ttgd_pkg::READS_WIDTH-1:0];
        end
        ttgd_pkg::REG_LONG_PRESS_MS: begin
          cfg.long_press_ms <= ttgd_pkg::MS_WIDTH'(cfg_data);
        end
        ttgd_pkg::REG_TAP_WINDOW_MS: begin
          cfg.tap_window_ms <= ttgd_pkg::MS_WIDTH'(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

  // input stage: control
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // input stage: payload, only the used low bits are kept
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_sample <= touch_sample[SAMPLE_WIDTH-1:0];
      stage_now    <= now_ms[TIME_WIDTH-1:0];
    end
  end

  ttgd_debounce #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_debounce (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .sample  (stage_sample),
    .cfg     (cfg),
    .down    (down)
  );

  ttgd_gesture #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_gesture (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .down    (down),
    .now     (stage_now),
    .cfg     (cfg),
    .res     (res)
  );

  // result register: control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register: payload
  always_ff @(posedge clk) begin
    if (advance) begin
      result <= res;
    end
  end

  assign a_pressed      = result.a_pressed;
  assign a_was_pressed  = result.a_was_pressed;
  assign a_was_released = result.a_was_released;
  assign a_press_time   = result.a_press_time;
  assign b_pressed      = result.b_pressed;
  assign b_was_pressed  = result.b_was_pressed;
  assign b_was_released = result.b_was_released;
  assign b_press_time   = result.b_press_time;

  // an empty input register always takes a new poll
  `ASSERT_CLK(a_ready_when_empty, clk, rst, !stage_valid |-> in_ready)
  // a b press edge comes with b held
  `ASSERT_CLK(a_b_press_level, clk, rst, out_valid && b_was_pressed |-> b_pressed)
  // a b release edge comes with b let go
  `ASSERT_CLK(a_b_release_level, clk, rst, out_valid && b_was_released |-> !b_pressed)

endmodule

// ----- hdl/ttgd_debounce.sv -----
// threshold compare and debounce counter for the touch pad
// depends on ttgd_pkg and assert_macros.svh
`include "assert_macros.svh"

module ttgd_debounce #(
  parameter int SAMPLE_WIDTH = ttgd_pkg::SAMPLE_WIDTH_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    advance,
  input  logic [SAMPLE_WIDTH-1:0] sample,
  input  ttgd_pkg::cfg_t          cfg,
  output logic                    down
);

  logic                               debounced_down;
  logic                               debounced_down_next;
  logic [ttgd_pkg::READS_WIDTH-1:0]   disagree_count;
  logic [ttgd_pkg::READS_WIDTH-1:0]   disagree_count_next;
  logic [ttgd_pkg::READS_WIDTH-1:0]   count_inc;
  logic                               raw;

  assign raw       = ttgd_pkg::THRESHOLD_WIDTH'(sample) < cfg.touch_threshold;
  assign count_inc = disagree_count + ttgd_pkg::READS_WIDTH'(1);

  always_comb begin
    debounced_down_next = debounced_down;
    disagree_count_next = '0;
    if (raw != debounced_down) begin
      // a read count of zero behaves like one
      if (count_inc >= cfg.debounce_reads) begin
        debounced_down_next = raw;
      end else begin
        disagree_count_next = count_inc;
      end
    end
  end

  assign down = debounced_down_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounced_down <= 1'b0;
      disagree_count <= '0;
    end else if (advance) begin
      debounced_down <= debounced_down_next;
      disagree_count <= disagree_count_next;
    end
  end

  // the counter stays below the largest read count
  `ASSERT_CLK(a_count_below_max, clk, rst, disagree_count != '1)

endmodule

// ----- hdl/ttgd_gesture.sv -----
// tap, double tap and long press tracking with the two button pulse sequencers
// depends on ttgd_pkg and assert_macros.svh
`include "assert_macros.svh"

module ttgd_gesture #(
  parameter int TIME_WIDTH = ttgd_pkg::TIME_WIDTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  down,
  input  logic [TIME_WIDTH-1:0] now,
  input  ttgd_pkg::cfg_t        cfg,
  output ttgd_pkg::result_t     res
);

  logic                  previous_down;
  logic [TIME_WIDTH-1:0] touch_start_time, touch_start_time_next;
  logic                  long_fired, long_fired_next;
  logic                  tap_pending, tap_pending_next;
  logic [TIME_WIDTH-1:0] first_tap_time, first_tap_time_next;
  logic                  a_level, a_level_next;
  logic [1:0]            a_pulse_phase, a_pulse_phase_next;
  logic [TIME_WIDTH-1:0] a_start_time, a_start_time_next;
  logic                  b_level, b_level_next;
  logic [1:0]            b_pulse_phase, b_pulse_phase_next;
  logic [TIME_WIDTH-1:0] b_start_time, b_start_time_next;

  logic [TIME_WIDTH-1:0] long_limit;
  logic [TIME_WIDTH-1:0] tap_limit;
  logic [TIME_WIDTH-1:0] held_time;
  logic [TIME_WIDTH-1:0] gap_time;
  logic [TIME_WIDTH-1:0] lapse_time;
  logic                  a_pe, a_re, b_pe, b_re;

  assign long_limit = TIME_WIDTH'(cfg.long_press_ms);
  assign tap_limit  = TIME_WIDTH'(cfg.tap_window_ms);
  assign gap_time   = now - first_tap_time;

  always_comb begin
    touch_start_time_next = touch_start_time;
    long_fired_next       = long_fired;
    tap_pending_next      = tap_pending;
    first_tap_time_next   = first_tap_time;
    a_level_next          = a_level;
    a_pulse_phase_next    = a_pulse_phase;
    a_start_time_next     = a_start_time;
    b_level_next          = b_level;
    b_pulse_phase_next    = b_pulse_phase;
    b_start_time_next     = b_start_time;
    a_pe = 1'b0;
    a_re = 1'b0;
    b_pe = 1'b0;
    b_re = 1'b0;

    // touch start
    if (down && !previous_down) begin
      touch_start_time_next = now;
      long_fired_next       = 1'b0;
    end
    held_time = now - touch_start_time_next;

    // long press
    if (down && !long_fired_next && held_time >= long_limit) begin
      long_fired_next   = 1'b1;
      tap_pending_next  = 1'b0;
      a_level_next      = 1'b1;
      a_pe              = 1'b1;
      a_start_time_next = touch_start_time_next;
    end
    if (down && long_fired_next) begin
      a_level_next = 1'b1;
    end

    // release: end of a long press, or a tap
    if (!down && previous_down) begin
      if (long_fired_next) begin
        a_level_next = 1'b0;
        a_re         = 1'b1;
      end else if (held_time < long_limit) begin
        if (tap_pending_next && gap_time <= tap_limit) begin
          tap_pending_next   = 1'b0;
          b_pulse_phase_next = ttgd_pkg::PHASE_PRESS;
        end else begin
          tap_pending_next    = 1'b1;
          first_tap_time_next = now;
        end
      end
    end

    // lone tap once the double-tap window has lapsed
    lapse_time = now - first_tap_time_next;
    if (tap_pending_next && !down && lapse_time > tap_limit) begin
      tap_pending_next   = 1'b0;
      a_pulse_phase_next = ttgd_pkg::PHASE_PRESS;
    end

    case (a_pulse_phase_next)
      ttgd_pkg::PHASE_PRESS: begin
        a_level_next       = 1'b1;
        a_pe               = 1'b1;
        a_start_time_next  = now;
        a_pulse_phase_next = ttgd_pkg::PHASE_RELEASE;
      end
      ttgd_pkg::PHASE_RELEASE: begin
        a_level_next       = 1'b0;
        a_re               = 1'b1;
        a_pulse_phase_next = ttgd_pkg::PHASE_IDLE;
      end
      default: begin
      end
    endcase

    case (b_pulse_phase_next)
      ttgd_pkg::PHASE_PRESS: begin
        b_level_next       = 1'b1;
        b_pe               = 1'b1;
        b_start_time_next  = now;
        b_pulse_phase_next = ttgd_pkg::PHASE_RELEASE;
      end
      ttgd_pkg::PHASE_RELEASE: begin
        b_level_next       = 1'b0;
        b_re               = 1'b1;
        b_pulse_phase_next = ttgd_pkg::PHASE_IDLE;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.a_pressed      = a_level_next;
    res.a_was_pressed  = a_pe;
    res.a_was_released = a_re;
    res.a_press_time   = ttgd_pkg::TIME_PORT_WIDTH'(a_start_time_next);
    res.b_pressed      = b_level_next;
    res.b_was_pressed  = b_pe;
    res.b_was_released = b_re;
    res.b_press_time   = ttgd_pkg::TIME_PORT_WIDTH'(b_start_time_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_down    <= 1'b0;
      touch_start_time <= '0;
      long_fired       <= 1'b0;
      tap_pending      <= 1'b0;
      first_tap_time   <= '0;
      a_level          <= 1'b0;
      a_pulse_phase    <= ttgd_pkg::PHASE_IDLE;
      a_start_time     <= '0;
      b_level          <= 1'b0;
      b_pulse_phase    <= ttgd_pkg::PHASE_IDLE;
      b_start_time     <= '0;
    end else if (advance) begin
      previous_down    <= down;
      touch_start_time <= touch_start_time_next;
      long_fired       <= long_fired_next;
      tap_pending      <= tap_pending_next;
      first_tap_time   <= first_tap_time_next;
      a_level          <= a_level_next;
      a_pulse_phase    <= a_pulse_phase_next;
      a_start_time     <= a_start_time_next;
      b_level          <= b_level_next;
      b_pulse_phase    <= b_pulse_phase_next;
      b_start_time     <= b_start_time_next;
    end
  end

  // pulse sequencers never reach the unused phase
  `ASSERT_CLK(a_a_phase_valid, clk, rst, a_pulse_phase != ttgd_pkg::PHASE_UNUSED)
  `ASSERT_CLK(a_b_phase_valid, clk, rst, b_pulse_phase != ttgd_pkg::PHASE_UNUSED)

endmodule
